/* sv/dnwm_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// dnwm_pkg
// Shared constants and types of the 8.3 directory-name wildcard matcher.
// ============================================================================
package dnwm_pkg;

    // Pattern storage in the configuration registers, in characters.
    localparam int STORED_CHARS  = 16;
    localparam int PATTERN_MAX   = 16;
    localparam int NAME_PART_MAX = 8;
    localparam int EXT_PART_MAX  = 3;

    // Pattern positions that the automaton tracks.
    localparam int PAT_SLOTS = (PATTERN_MAX < STORED_CHARS) ? PATTERN_MAX : STORED_CHARS;
    localparam int AUTO_W    = PAT_SLOTS + 1;
    localparam int POS_W     = $clog2(PAT_SLOTS + 1);

    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 5;
    localparam int NAME_CNT_W = $clog2(NAME_PART_MAX + 1);
    localparam int EXT_CNT_W  = $clog2(EXT_PART_MAX + 1);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } t_cfg_idx;

    // How far a name that opens with a dot has got.
    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_ONE  = 2'd1,
        LEAD_TWO  = 2'd2
    } t_lead;

    typedef logic [AUTO_W-1:0] t_auto;

endpackage

/* sv/dnwm_in_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// dnwm_in_if
// Name byte channel: one byte of a directory entry name per transfer.
// ============================================================================
interface dnwm_in_if;
    import dnwm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] name_char;
    logic              name_last;

    modport source (output valid, output name_char, output name_last, input ready);
    modport sink   (input valid, input name_char, input name_last, output ready);
endinterface

/* sv/dnwm_out_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// dnwm_out_if
// Result channel: one match decision per name.
// ============================================================================
interface dnwm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic name_valid;

    modport source (output valid, output matched, output name_valid, input ready);
    modport sink   (input valid, input matched, input name_valid, output ready);
endinterface

/* sv/dnwm_cfg_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// dnwm_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface dnwm_cfg_if;
    import dnwm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/dos_name_wildcard_matcher_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// dos_name_wildcard_matcher_core
// Matches 8.3 directory entry names, one byte per transfer, against a
// wildcard pattern of up to 16 characters.
// ============================================================================
// The block takes one name byte per clock cycle, back to back, with no gaps
// between names, unless a final byte is held by a full output register. A byte
// lands in an input register and is folded into the bit-parallel pattern
// automaton and the 8.3 counters on the next edge, but for such a held final
// byte; on the final byte of a name the decision is written to an output
// register, so the result passes the input register and then the output
// register. The output register lets the next name stream in while a decision
// waits to be taken. Each position of the pattern is one bit of the automaton,
// each star-run closure takes a single adder, and pattern writes act on later bytes.
module dos_name_wildcard_matcher_core (
    input  logic i_clk,
    input  logic i_rst_n,
    dnwm_in_if.sink    i_in,
    dnwm_cfg_if.sink   i_cfg,
    dnwm_out_if.source o_res
);
    import dnwm_pkg::*;

    // Reach every position that a run of stars lets the set slide over.
    // The carries of (s & m) + m run exactly along the star runs.
    function automatic t_auto f_closure(input t_auto s, input t_auto m);
        t_auto a;
        t_auto sum;
        a   = s & m;
        sum = a + m;
        return s | (sum ^ a ^ m);
    endfunction

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_W-1:0]      r_pat_len;

    // Input register.
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // Per-name state.
    t_auto                 r_active, n_active;
    logic [NAME_CNT_W-1:0] r_name_cnt, n_name_cnt;
    logic [EXT_CNT_W-1:0]  r_ext_cnt, n_ext_cnt;
    logic                  r_dot_seen, n_dot_seen;
    logic                  r_broken, n_broken;
    t_lead                 r_lead, n_lead;
    logic                  r_all_dots, n_all_dots;
    logic                  r_first, n_first;
    logic                  r_ended, n_ended;

    // Output register.
    logic r_out_valid;
    logic r_matched, n_matched;
    logic r_name_valid;

    logic [CHAR_W-1:0]    w_pat [PAT_SLOTS];
    logic [PAT_SLOTS-1:0] w_slot_ok;
    logic [POS_W-1:0]     w_len;
    logic [PAT_SLOTS-1:0] w_in_len;
    logic [PAT_SLOTS-1:0] w_step_m;
    t_auto                w_star_m;
    t_auto                w_pre;
    t_auto                w_nxt;
    t_auto                w_adv;
    t_auto                w_start;
    t_lead                w_lead_now;
    logic                 w_feed;
    logic                 w_star_dot_star;
    logic                 w_out_free;
    logic                 w_proc;
    logic                 w_in_take;

    // ------------------------------------------------------------------------
    // Pattern decode
    // ------------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < PAT_SLOTS; i++) begin
            if (i < 8) begin
                w_pat[i] = r_pat_low[8*i +: 8];
            end else begin
                w_pat[i] = r_pat_high[8*(i-8) +: 8];
            end
            w_slot_ok[i] = (LEN_W'(i) < r_pat_len) && (w_pat[i] != CHAR_NUL);
        end
    end

    // The pattern ends at the register length or at its first zero byte.
    always_comb begin
        w_len = POS_W'(PAT_SLOTS);
        for (int i = PAT_SLOTS - 1; i >= 0; i--) begin
            if (!w_slot_ok[i]) begin
                w_len = POS_W'(i);
            end
        end
    end

    always_comb begin
        w_star_m = '0;
        for (int i = 0; i < PAT_SLOTS; i++) begin
            w_in_len[i] = POS_W'(i) < w_len;
            w_star_m[i] = w_in_len[i] && (w_pat[i] == CHAR_STAR);
            w_step_m[i] = w_in_len[i] && (w_pat[i] != CHAR_STAR) &&
                          ((w_pat[i] == CHAR_QMARK) || (w_pat[i] == r_in_char));
        end
    end

    assign w_star_dot_star = (w_len == POS_W'(3)) && (w_pat[0] == CHAR_STAR) &&
                             (w_pat[1] == CHAR_DOT) && (w_pat[2] == CHAR_STAR);

    // ------------------------------------------------------------------------
    // Automaton step
    // ------------------------------------------------------------------------
    assign w_pre   = f_closure(r_active, w_star_m);
    assign w_start = f_closure(t_auto'(1), w_star_m);

    always_comb begin
        w_nxt = '0;
        for (int i = 0; i < PAT_SLOTS; i++) begin
            w_nxt[i]   = w_nxt[i] | (w_pre[i] & w_star_m[i]);
            w_nxt[i+1] = w_pre[i] & w_step_m[i];
        end
    end

    assign w_adv = f_closure(w_nxt, w_star_m);

    // ------------------------------------------------------------------------
    // 8.3 rule
    // ------------------------------------------------------------------------
    always_comb begin
        n_name_cnt = r_name_cnt;
        n_ext_cnt  = r_ext_cnt;
        n_dot_seen = r_dot_seen;
        n_broken   = r_broken;
        n_lead     = r_lead;
        n_all_dots = r_all_dots;
        n_first    = r_first;
        n_ended    = r_ended;
        w_feed     = 1'b0;
        w_lead_now = r_lead;
        if (!r_ended && !r_broken) begin
            if (r_in_char == CHAR_NUL) begin
                n_ended = 1'b1;
            end else begin
                n_first = 1'b0;
                if (r_first && (r_in_char == CHAR_DOT)) begin
                    w_lead_now = LEAD_ONE;
                end
                n_all_dots = r_all_dots && (r_in_char == CHAR_DOT);
                n_lead     = w_lead_now;
                if (w_lead_now != LEAD_NONE) begin
                    // Only "." and ".." survive a leading dot.
                    if ((w_lead_now == LEAD_ONE) && n_all_dots) begin
                        w_feed = 1'b1;
                        if ((r_name_cnt == '0) && (r_ext_cnt == '0) && !r_dot_seen) begin
                            n_dot_seen = 1'b1;
                        end else begin
                            n_lead = LEAD_TWO;
                        end
                    end else begin
                        n_broken = 1'b1;
                    end
                end else if (!r_dot_seen) begin
                    if (r_in_char == CHAR_DOT) begin
                        n_dot_seen = 1'b1;
                        w_feed     = 1'b1;
                    end else if (r_name_cnt < NAME_CNT_W'(NAME_PART_MAX)) begin
                        n_name_cnt = r_name_cnt + NAME_CNT_W'(1);
                        w_feed     = 1'b1;
                    end else begin
                        n_broken = 1'b1;
                    end
                end else begin
                    if (r_ext_cnt < EXT_CNT_W'(EXT_PART_MAX)) begin
                        n_ext_cnt = r_ext_cnt + EXT_CNT_W'(1);
                        w_feed    = 1'b1;
                    end else begin
                        n_broken = 1'b1;
                    end
                end
            end
        end
    end

    assign n_active = w_feed ? w_adv : r_active;

    // A broken name is matched as the empty name.
    always_comb begin
        if (w_star_dot_star) begin
            n_matched = 1'b1;
        end else if (n_broken) begin
            n_matched = w_start[w_len];
        end else if (w_feed) begin
            n_matched = w_adv[w_len];
        end else begin
            n_matched = w_pre[w_len];
        end
    end

    // ------------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------------
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_proc     = r_in_valid && (!r_in_last || w_out_free);
    assign w_in_take  = i_in.valid && i_in.ready;

    assign i_in.ready       = !r_in_valid || w_proc;
    assign i_cfg.ready      = 1'b1;
    assign o_res.valid      = r_out_valid;
    assign o_res.matched    = r_matched;
    assign o_res.name_valid = r_name_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_PAT_LOW:  r_pat_low  <= i_cfg.data;
                CFG_PAT_HIGH: r_pat_high <= i_cfg.data;
                CFG_PAT_LEN:  r_pat_len  <= i_cfg.data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char <= i_in.name_char;
            r_in_last <= i_in.name_last;
        end
    end

    // The final byte of a name restarts the state with the current pattern.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= t_auto'(1);
            r_name_cnt <= '0;
            r_ext_cnt  <= '0;
            r_dot_seen <= 1'b0;
            r_broken   <= 1'b0;
            r_lead     <= LEAD_NONE;
            r_all_dots <= 1'b1;
            r_first    <= 1'b1;
            r_ended    <= 1'b0;
        end else if (w_proc) begin
            if (r_in_last) begin
                r_active   <= w_start;
                r_name_cnt <= '0;
                r_ext_cnt  <= '0;
                r_dot_seen <= 1'b0;
                r_broken   <= 1'b0;
                r_lead     <= LEAD_NONE;
                r_all_dots <= 1'b1;
                r_first    <= 1'b1;
                r_ended    <= 1'b0;
            end else begin
                r_active   <= n_active;
                r_name_cnt <= n_name_cnt;
                r_ext_cnt  <= n_ext_cnt;
                r_dot_seen <= n_dot_seen;
                r_broken   <= n_broken;
                r_lead     <= n_lead;
                r_all_dots <= n_all_dots;
                r_first    <= n_first;
                r_ended    <= n_ended;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            r_matched    <= n_matched;
            r_name_valid <= !n_broken;
        end
    end

`ifndef SYNTHESIS
    // A waiting byte is never dropped or overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_proc) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_last)))
        else $error("input register changed before its byte was used");

    // A final byte never passes while an untaken decision is still waiting.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !(w_proc && r_in_last))
        else $error("decision overwritten before transfer");

    // After the final byte the name state starts over.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_last) |=> (r_name_cnt == '0 && r_ext_cnt == '0 && !r_dot_seen &&
                                   !r_broken && r_first && r_all_dots && !r_ended))
        else $error("name state not restarted after final byte");

    // The part counters stay within the 8.3 limits.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_name_cnt <= NAME_CNT_W'(NAME_PART_MAX)) && (r_ext_cnt <= EXT_CNT_W'(EXT_PART_MAX)))
        else $error("8.3 part counter out of range");

    // A name can only break once some byte of it has been taken.
    a_broken_after_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_broken |-> !r_first)
        else $error("name broken before its first byte");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the 8.3 directory-name wildcard matcher.
// ============================================================================
// Name bytes go in over the input channel and every decision that comes out
// is checked against a behavioral copy of the matcher kept in this file. The
// copy tracks the 8.3 counters and the pattern automaton byte by byte. A short
// directed part covers the corner cases: empty and dot names, zero bytes in the
// name and the pattern, oversized lengths, the everything pattern, and pattern
// writes in the middle of a name. Random patterns and names follow, with
// bursty input, a stalling result side and one long result hold-off.
// ============================================================================
module tb;
    import dnwm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BYTE_TARGET   = 650;
    localparam logic [CHAR_W-1:0] LETTER_A = "A";

    typedef struct packed {
        logic matched;
        logic name_valid;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dnwm_in_if  in_if ();
    dnwm_cfg_if cfg_if ();
    dnwm_out_if res_if ();

    dos_name_wildcard_matcher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pattern registers as the block should hold them.
    logic [CFG_DATA_W-1:0] pat_lo_q;
    logic [CFG_DATA_W-1:0] pat_hi_q;
    logic [LEN_W-1:0]      pat_len_q;
    string                 cur_pattern;

    // Per-name tracking state.
    logic [31:0] live_positions;
    int          name_cnt;
    int          ext_cnt;
    bit          dot_seen;
    bit          broken;
    bit          all_dots;
    bit          first_pending;
    bit          ended;
    t_lead       lead;

    t_verdict    verdicts_q[$];
    logic [CHAR_W-1:0] name_buf[$];

    int errors;
    int bytes_sent;
    int names_sent;
    int matches_seen;
    int broken_seen;
    int patterns_loaded;
    int burst_left;
    int cycle_cnt;
    int holdoff_len;
    int holdoff_seq;

    // ------------------------------------------------------------------
    // Behavioral matcher
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] pattern_byte(int i);
        if (i < 8) begin
            return pat_lo_q[8*i +: 8];
        end
        if (i < 16) begin
            return pat_hi_q[8*(i-8) +: 8];
        end
        return CHAR_NUL;
    endfunction

    function automatic int pattern_span();
        int n;
        n = int'(pat_len_q);
        if (n > PATTERN_MAX) begin
            n = PATTERN_MAX;
        end
        if (n > STORED_CHARS) begin
            n = STORED_CHARS;
        end
        for (int i = 0; i < n; i++) begin
            if (pattern_byte(i) == CHAR_NUL) begin
                return i;
            end
        end
        return n;
    endfunction

    // A live position sitting on a star also makes the position after it live.
    function automatic logic [31:0] close_stars(logic [31:0] s, int n);
        for (int i = 0; i < n; i++) begin
            if (s[i] && pattern_byte(i) == CHAR_STAR) begin
                s[i+1] = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic logic [31:0] step_positions(logic [31:0] s, logic [CHAR_W-1:0] c,
                                                   int n);
        logic [31:0]       nxt;
        logic [CHAR_W-1:0] p;
        nxt = '0;
        s = close_stars(s, n);
        for (int i = 0; i < n; i++) begin
            if (s[i]) begin
                p = pattern_byte(i);
                if (p == CHAR_STAR) begin
                    nxt[i] = 1'b1;
                end else if (p == CHAR_QMARK || p == c) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        return close_stars(nxt, n);
    endfunction

    function automatic void restart_name();
        live_positions = close_stars(32'd1, pattern_span());
        name_cnt       = 0;
        ext_cnt        = 0;
        dot_seen       = 1'b0;
        broken         = 1'b0;
        lead           = LEAD_NONE;
        all_dots       = 1'b1;
        first_pending  = 1'b1;
        ended          = 1'b0;
    endfunction

    function automatic void fold_byte(logic [CHAR_W-1:0] c);
        bit feed;
        feed = 1'b0;
        if (ended || broken) begin
            return;
        end
        if (c == CHAR_NUL) begin
            ended = 1'b1;
            return;
        end
        if (first_pending) begin
            first_pending = 1'b0;
            if (c == CHAR_DOT) begin
                lead = LEAD_ONE;
            end
        end
        if (c != CHAR_DOT) begin
            all_dots = 1'b0;
        end
        if (lead != LEAD_NONE) begin
            // Only "." and ".." get past a leading dot.
            if (lead == LEAD_ONE && all_dots) begin
                feed = 1'b1;
                if (name_cnt == 0 && ext_cnt == 0 && !dot_seen) begin
                    dot_seen = 1'b1;
                end else begin
                    lead = LEAD_TWO;
                end
            end else begin
                broken = 1'b1;
            end
        end else if (!dot_seen) begin
            if (c == CHAR_DOT) begin
                dot_seen = 1'b1;
                feed = 1'b1;
            end else if (name_cnt < NAME_PART_MAX) begin
                name_cnt++;
                feed = 1'b1;
            end else begin
                broken = 1'b1;
            end
        end else if (ext_cnt < EXT_PART_MAX) begin
            ext_cnt++;
            feed = 1'b1;
        end else begin
            broken = 1'b1;
        end
        if (feed) begin
            live_positions = step_positions(live_positions, c, pattern_span())
                             & ((32'd1 << AUTO_W) - 1);
        end
    endfunction

    function automatic t_verdict decide_name();
        int          n;
        logic [31:0] s;
        t_verdict    v;
        n = pattern_span();
        if (n == 3 && pattern_byte(0) == CHAR_STAR && pattern_byte(1) == CHAR_DOT &&
            pattern_byte(2) == CHAR_STAR) begin
            v.matched = 1'b1;
        end else begin
            // A broken name is matched as the empty name.
            s = close_stars(broken ? 32'd1 : live_positions, n);
            v.matched = s[n];
        end
        v.name_valid = !broken;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [CHAR_W-1:0] c, input bit last);
        int       gap;
        t_verdict v;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(30, 80))
                                                     : int'($urandom_range(1, 12));
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.name_char <= c;
        in_if.name_last <= last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        fold_byte(c);
        bytes_sent++;
        if (last) begin
            v = decide_name();
            verdicts_q.push_back(v);
            names_sent++;
            matches_seen += int'(v.matched);
            broken_seen  += int'(!v.name_valid);
            restart_name();
        end
    endtask

    task automatic send_buf();
        if (name_buf.size() == 0) begin
            send_byte(CHAR_NUL, 1'b1);
        end else begin
            for (int i = 0; i < name_buf.size(); i++) begin
                send_byte(name_buf[i], i == name_buf.size() - 1);
            end
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            name_buf.push_back(s[i]);
        end
    endtask

    task automatic send_name(input string s);
        name_buf.delete();
        push_text(s);
        send_buf();
    endtask

    // Stop offering bytes, wait for every decision, then give the block time
    // to fold in any trailing byte that produces no result.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (verdicts_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_PAT_LOW:  pat_lo_q  = val;
            CFG_PAT_HIGH: pat_hi_q  = val;
            CFG_PAT_LEN:  pat_len_q = val[LEN_W-1:0];
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pattern(input string p);
        logic [2*CFG_DATA_W-1:0] packed_chars;
        packed_chars = '0;
        for (int i = 0; i < p.len() && i < STORED_CHARS; i++) begin
            packed_chars[8*i +: 8] = p[i];
        end
        drain_results();
        write_reg(CFG_PAT_LOW, packed_chars[CFG_DATA_W-1:0]);
        write_reg(CFG_PAT_HIGH, packed_chars[2*CFG_DATA_W-1:CFG_DATA_W]);
        write_reg(CFG_PAT_LEN, CFG_DATA_W'(p.len()));
        cur_pattern = p;
        patterns_loaded++;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern plus a requested long hold-off
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        int holdoff_seen;
        int ready_pct;
        int segment_left;
        hold_left    = 0;
        holdoff_seen = 0;
        ready_pct    = 100;
        segment_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_seq != holdoff_seen) begin
                holdoff_seen = holdoff_seq;
                hold_left    = holdoff_len;
            end
            if (segment_left == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                segment_left = int'($urandom_range(16, 96));
            end
            segment_left--;
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (verdicts_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got matched=%b name_valid=%b",
                         $time, res_if.matched, res_if.name_valid);
            end else begin
                want = verdicts_q.pop_front();
                if (res_if.matched !== want.matched) begin
                    errors++;
                    $display("%0t: matched expected %b, actual %b",
                             $time, want.matched, res_if.matched);
                end
                if (res_if.name_valid !== want.name_valid) begin
                    errors++;
                    $display("%0t: name_valid expected %b, actual %b",
                             $time, want.name_valid, res_if.name_valid);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            6:       return CHAR_DOT;
            7:       return CHAR_STAR;
            8:       return CHAR_QMARK;
            9:       return CHAR_W'($urandom_range(1, 255));
            default: return LETTER_A + CHAR_W'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_letter();
        if ($urandom_range(0, 7) == 0) begin
            return ($urandom_range(0, 1) == 0) ? CHAR_STAR : CHAR_QMARK;
        end
        return LETTER_A + CHAR_W'($urandom_range(0, 2));
    endfunction

    task automatic new_random_pattern();
        string             p;
        int                n;
        logic [CHAR_W-1:0] ch;
        p = "";
        case ($urandom_range(0, 11))
            0: set_pattern("*.*");
            1: begin
                // Raw register contents, zero bytes and oversized lengths included.
                drain_results();
                write_reg(CFG_PAT_LOW, {$urandom, $urandom});
                write_reg(CFG_PAT_HIGH, {$urandom, $urandom});
                write_reg(CFG_PAT_LEN, CFG_DATA_W'($urandom_range(0, 31)));
                cur_pattern = "";
                patterns_loaded++;
            end
            default: begin
                n = ($urandom_range(0, 5) == 0) ? int'($urandom_range(9, 16))
                                                : int'($urandom_range(0, 8));
                repeat (n) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: ch = CHAR_STAR;
                        3, 4:    ch = CHAR_QMARK;
                        5:       ch = CHAR_DOT;
                        9:       ch = CHAR_W'($urandom_range(1, 255));
                        default: ch = LETTER_A + CHAR_W'($urandom_range(0, 2));
                    endcase
                    p = $sformatf("%s%c", p, ch);
                end
                set_pattern(p);
            end
        endcase
    endtask

    task automatic make_name();
        int                kind;
        logic [CHAR_W-1:0] ch;
        name_buf.delete();
        kind = int'($urandom_range(0, 15));
        if (kind <= 6 && cur_pattern.len() == 0) begin
            kind = 7;
        end
        if (kind <= 6) begin
            // Built from the pattern itself, so that most of these match.
            for (int i = 0; i < cur_pattern.len(); i++) begin
                ch = cur_pattern[i];
                if (ch == CHAR_STAR) begin
                    repeat ($urandom_range(0, 2)) name_buf.push_back(pick_char());
                end else if (ch == CHAR_QMARK) begin
                    name_buf.push_back(pick_char());
                end else begin
                    name_buf.push_back(ch);
                end
            end
        end else if (kind <= 10) begin
            repeat ($urandom_range(1, NAME_PART_MAX)) name_buf.push_back(pick_letter());
            if ($urandom_range(0, 1) == 1) begin
                name_buf.push_back(CHAR_DOT);
                repeat ($urandom_range(0, EXT_PART_MAX)) begin
                    name_buf.push_back(($urandom_range(0, 5) == 0) ? CHAR_DOT : pick_letter());
                end
            end
        end else if (kind == 11) begin
            case ($urandom_range(0, 4))
                0:       push_text(".");
                1:       push_text("..");
                2:       push_text("...");
                3:       push_text(".A");
                default: push_text("..A");
            endcase
        end else if (kind == 12) begin
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(NAME_PART_MAX + 1, NAME_PART_MAX + 3)) begin
                    name_buf.push_back(pick_letter());
                end
            end else begin
                repeat ($urandom_range(1, 3)) name_buf.push_back(pick_letter());
                name_buf.push_back(CHAR_DOT);
                repeat ($urandom_range(EXT_PART_MAX + 1, EXT_PART_MAX + 2)) begin
                    name_buf.push_back(pick_letter());
                end
            end
        end else if (kind == 13) begin
            repeat ($urandom_range(1, 10)) name_buf.push_back(CHAR_W'($urandom_range(0, 255)));
        end else if (kind == 14) begin
            repeat ($urandom_range(1, 3)) name_buf.push_back(pick_letter());
            name_buf.push_back(CHAR_NUL);
            repeat ($urandom_range(1, 3)) name_buf.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        // The remaining kind leaves the buffer empty: a lone zero byte.
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_pattern();
        // The empty pattern after reset accepts only the empty name.
        send_name("");
        send_name("A");
    endtask

    task automatic test_pattern_extremes();
        drain_results();
        write_reg(CFG_PAT_LOW, '1);
        write_reg(CFG_PAT_HIGH, '1);
        write_reg(CFG_PAT_LEN, '1);
        patterns_loaded++;
        send_byte(8'hFF, 1'b1);
        drain_results();
        write_reg(CFG_PAT_LOW, '0);
        write_reg(CFG_PAT_HIGH, '0);
        write_reg(CFG_PAT_LEN, CFG_DATA_W'(STORED_CHARS));
        patterns_loaded++;
        send_name("B");
    endtask

    task automatic test_everything_pattern();
        set_pattern("*.*");
        send_name("A.XYZ");
    endtask

    task automatic test_dot_names();
        set_pattern("?*");
        send_name(".");
        send_name("..");
        send_name("...");
        send_name(".A");
        send_name("**");
        set_pattern("*Z");
        send_name("ABCDEFGH.XYZ");
    endtask

    task automatic test_zero_bytes();
        // Pattern "A", NUL, "*": only the "A" counts.
        drain_results();
        write_reg(CFG_PAT_LOW, {40'd0, CHAR_STAR, CHAR_NUL, LETTER_A});
        write_reg(CFG_PAT_HIGH, '0);
        write_reg(CFG_PAT_LEN, CFG_DATA_W'(3));
        patterns_loaded++;
        send_byte(LETTER_A, 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_mid_name_write();
        // The automaton keeps its positions when the pattern changes under it.
        set_pattern("A?C");
        send_byte(LETTER_A, 1'b0);
        send_byte(LETTER_A + 8'd1, 1'b0);
        set_pattern("AB*");
        send_byte(8'h58, 1'b1);
    endtask

    task automatic test_result_backpressure();
        set_pattern("?*");
        holdoff_len = 300;
        holdoff_seq++;
        repeat (25) begin
            name_buf.delete();
            repeat ($urandom_range(1, 2)) name_buf.push_back(pick_letter());
            send_buf();
        end
        drain_results();
    endtask

    task automatic test_random_names();
        while (bytes_sent < BYTE_TARGET) begin
            new_random_pattern();
            repeat ($urandom_range(6, 16)) begin
                make_name();
                send_buf();
            end
        end
        drain_results();
    endtask

    initial begin
        errors          = 0;
        bytes_sent      = 0;
        names_sent      = 0;
        matches_seen    = 0;
        broken_seen     = 0;
        patterns_loaded = 0;
        burst_left      = 0;
        cycle_cnt       = 0;
        holdoff_len     = 0;
        holdoff_seq     = 0;
        pat_lo_q        = '0;
        pat_hi_q        = '0;
        pat_len_q       = '0;
        cur_pattern     = "";
        restart_name();

        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.name_char <= '0;
        in_if.name_last <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_pattern();
        test_pattern_extremes();
        test_everything_pattern();
        test_dot_names();
        test_zero_bytes();
        test_mid_name_write();
        test_result_backpressure();
        test_random_names();

        drain_results();
        repeat (16) @(posedge i_clk);
        $display("Checked %0d names (%0d bytes) against %0d pattern loads.",
                 names_sent, bytes_sent, patterns_loaded);
        $display("%0d names matched, %0d broke the 8.3 rule.", matches_seen, broken_seen);
        if (errors == 0 && verdicts_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
